>>> sv/go_back_n_sender_window_defines.svh
// Assertion macros for the Go-Back-N sender window.
// Taken in by `include; no dependencies of its own.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons)
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/gbn_pkg.sv
// Shared types, widths and codes for the Go-Back-N sender window.
// No dependencies; compiled first.
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int WINDOW_SIZE  = 4;
  localparam int SEQ_BITS     = 3;
  localparam int SLOT_BITS    = 2;
  localparam int CNT_BITS     = 3;
  localparam int PAYLOAD_BITS = 64;
  localparam int KIND_BITS    = 2;
  localparam int STATUS_BITS  = 3;
  localparam int TCMD_BITS    = 2;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [SLOT_BITS-1:0]    slot_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [KIND_BITS-1:0]    kind_t;

  localparam kind_t KIND_SEND    = 2'd0;
  localparam kind_t KIND_ACK     = 2'd1;
  localparam kind_t KIND_TIMEOUT = 2'd2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_SENT        = 3'd0,
    ST_RESENT      = 3'd1,
    ST_REFUSED     = 3'd2,
    ST_ACK_OK      = 3'd3,
    ST_ACK_IGNORED = 3'd4
  } status_t;

  typedef enum logic [TCMD_BITS-1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } tcmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

endpackage

>>> sv/gbn_in_if.sv
// Valid/ready channel carrying one input item of the Go-Back-N sender.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
interface gbn_in_if;
  logic                     valid;
  logic                     ready;
  gbn_pkg::kind_t           kind;
  gbn_pkg::payload_t        payload_word;
  gbn_pkg::seq_t            ack_num;
  logic                     ack_checksum_ok;
  gbn_pkg::seq_t            timeout_seq;

  modport source (output valid, kind, payload_word, ack_num, ack_checksum_ok, timeout_seq,
                  input ready);
  modport sink (input valid, kind, payload_word, ack_num, ack_checksum_ok, timeout_seq,
                output ready);
endinterface

>>> sv/gbn_out_if.sv
// Valid/ready channel carrying one result item of the Go-Back-N sender.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
interface gbn_out_if;
  logic                              valid;
  logic                              ready;
  logic [gbn_pkg::STATUS_BITS-1:0]   status;
  gbn_pkg::seq_t                     seq_num;
  gbn_pkg::payload_t                 packet_payload;
  logic [gbn_pkg::TCMD_BITS-1:0]     timer_cmd;
  gbn_pkg::seq_t                     timer_seq;
  logic                              window_full;
  logic                              last;

  modport source (output valid, status, seq_num, packet_payload, timer_cmd, timer_seq,
                  window_full, last, input ready);
  modport sink (input valid, status, seq_num, packet_payload, timer_cmd, timer_seq,
                window_full, last, output ready);
endinterface

>>> sv/gbn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/go_back_n_sender_window.sv
// Go-Back-N sender window: top level with window control and payload store.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_ram and the defines header.
//
// Usage: items arrive on req (valid/ready); results leave on rsp (valid/ready).
// A send item stores its payload and emits a new packet, or is refused when
// four are outstanding. An ack item with a good checksum for an outstanding
// packet releases every packet up to it and issues the timer command; any
// other ack is reported as ignored. A timeout resends every outstanding
// packet, oldest first, as a burst of up to four beats; only the last beat
// has last set. Unknown kinds and a timeout on an empty window give no beat.
// A send or ack result is registered and shows on rsp in the cycle after
// its item is accepted; the first resend of a timeout passes through the
// RAM read register and then the output register. Sends and acks are taken
// one per cycle while rsp does not stall. A timeout holds req until its
// burst is done, one resend per cycle while rsp does not stall, paced by
// the single read port of the payload RAM.
// Reset clears the window (base, next sequence number and count) and the
// output valid flag; the payload RAM is not cleared and needs no sweep.
// When the receiver stalls, the result is held and req takes no new item
// until the pending beat has left.
`timescale 1ns / 1ps
`include "go_back_n_sender_window_defines.svh"
module go_back_n_sender_window (
  input logic       clk,
  input logic       rst,
  gbn_in_if.sink    req,
  gbn_out_if.source rsp
);

  gbn_pkg::state_t   state, state_next;
  gbn_pkg::seq_t     base_seq, next_seq;
  gbn_pkg::cnt_t     count;
  gbn_pkg::slot_t    idx;
  gbn_pkg::cnt_t     nres;
  gbn_pkg::seq_t     tseq;

  logic              out_valid;
  gbn_pkg::status_t  out_status;
  gbn_pkg::seq_t     out_seq;
  gbn_pkg::payload_t out_payload;
  gbn_pkg::tcmd_t    out_tcmd;
  gbn_pkg::seq_t     out_tseq;
  logic              out_full;
  logic              out_last;

  logic              acc, free, full;
  logic              is_send, is_ack, is_timeout;
  gbn_pkg::seq_t     ack_off;
  gbn_pkg::cnt_t     rel, count_after_ack;
  logic              ack_good;

  gbn_pkg::status_t  imm_status;
  gbn_pkg::seq_t     imm_seq;
  gbn_pkg::payload_t imm_payload;
  gbn_pkg::tcmd_t    imm_tcmd;
  gbn_pkg::seq_t     imm_tseq;
  logic              imm_full;

  logic              last_rs;
  logic              load_imm, load_rs, load_out;
  logic              mem_we, mem_re;
  gbn_pkg::slot_t    mem_raddr;
  gbn_pkg::payload_t mem_rdata;

  assign free       = !out_valid || rsp.ready;
  assign acc        = req.valid && req.ready;
  assign full       = (count == gbn_pkg::cnt_t'(gbn_pkg::WINDOW_SIZE));
  assign is_send    = (req.kind == gbn_pkg::KIND_SEND);
  assign is_ack     = (req.kind == gbn_pkg::KIND_ACK);
  assign is_timeout = (req.kind == gbn_pkg::KIND_TIMEOUT);

  // Offset of the acked packet from the head; it is outstanding when the
  // offset lies below the count.
  assign ack_off         = req.ack_num - base_seq;
  assign ack_good        = (gbn_pkg::cnt_t'(ack_off) < count) && req.ack_checksum_ok;
  assign rel             = gbn_pkg::cnt_t'(ack_off) + gbn_pkg::cnt_t'(1);
  assign count_after_ack = count - rel;

  assign last_rs = (gbn_pkg::cnt_t'(idx) + gbn_pkg::cnt_t'(1) == nres);

  // Result of a send or an ack, decided in the accepting cycle.
  always_comb begin
    imm_status  = gbn_pkg::ST_ACK_IGNORED;
    imm_seq     = req.ack_num;
    imm_payload = '0;
    imm_tcmd    = gbn_pkg::TMR_NONE;
    imm_tseq    = '0;
    imm_full    = full;
    if (is_send) begin
      if (full) begin
        imm_status = gbn_pkg::ST_REFUSED;
        imm_seq    = '0;
      end else begin
        imm_status  = gbn_pkg::ST_SENT;
        imm_seq     = next_seq;
        imm_payload = req.payload_word;
        imm_full    = (count + gbn_pkg::cnt_t'(1) == gbn_pkg::cnt_t'(gbn_pkg::WINDOW_SIZE));
        if (count == '0) begin
          imm_tcmd = gbn_pkg::TMR_START;
          imm_tseq = next_seq;
        end
      end
    end else if (ack_good) begin
      imm_status = gbn_pkg::ST_ACK_OK;
      imm_full   = 1'b0;
      if (count_after_ack != '0) begin
        imm_tcmd = gbn_pkg::TMR_RESTART;
        imm_tseq = req.ack_num + gbn_pkg::seq_t'(1);
      end else begin
        imm_tcmd = gbn_pkg::TMR_STOP;
        imm_tseq = base_seq;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::S_IDLE: begin
        if (acc && is_timeout && count != '0) begin
          state_next = gbn_pkg::S_EMIT;
        end
      end
      gbn_pkg::S_EMIT: begin
        if (free && last_rs) begin
          state_next = gbn_pkg::S_IDLE;
        end
      end
      default: state_next = gbn_pkg::S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake, output loads and RAM controls.
  always_comb begin
    req.ready = 1'b0;
    load_imm  = 1'b0;
    load_rs   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = base_seq[gbn_pkg::SLOT_BITS-1:0];
    case (state)
      gbn_pkg::S_IDLE: begin
        req.ready = free;
        load_imm  = acc && (is_send || is_ack);
        mem_we    = acc && is_send && !full;
        mem_re    = acc && is_timeout;
      end
      gbn_pkg::S_EMIT: begin
        load_rs = free;
        // Fetch the following packet as the current one moves out.
        mem_re    = free && !last_rs;
        mem_raddr = base_seq[gbn_pkg::SLOT_BITS-1:0] + idx + gbn_pkg::slot_t'(1);
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign load_out = load_imm || load_rs;

  // Packets live at the slot given by the low bits of their sequence number.
  gbn_ram #(
    .WIDTH (gbn_pkg::PAYLOAD_BITS),
    .DEPTH (gbn_pkg::WINDOW_SIZE)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (next_seq[gbn_pkg::SLOT_BITS-1:0]),
    .wr_data (req.payload_word),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbn_pkg::S_IDLE;
      base_seq  <= '0;
      next_seq  <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (acc && is_send && !full) begin
        next_seq <= next_seq + gbn_pkg::seq_t'(1);
        count    <= count + gbn_pkg::cnt_t'(1);
      end
      if (acc && is_ack && ack_good) begin
        base_seq <= req.ack_num + gbn_pkg::seq_t'(1);
        count    <= count_after_ack;
      end
      if (acc && is_timeout) begin
        idx <= '0;
      end else if (load_rs) begin
        idx <= idx + gbn_pkg::slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_timeout) begin
      nres <= count;
      tseq <= req.timeout_seq;
    end
    if (load_imm) begin
      out_status  <= imm_status;
      out_seq     <= imm_seq;
      out_payload <= imm_payload;
      out_tcmd    <= imm_tcmd;
      out_tseq    <= imm_tseq;
      out_full    <= imm_full;
      out_last    <= 1'b1;
    end else if (load_rs) begin
      out_status  <= gbn_pkg::ST_RESENT;
      out_seq     <= base_seq + gbn_pkg::seq_t'(idx);
      out_payload <= mem_rdata;
      out_tcmd    <= (idx == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
      out_tseq    <= (idx == '0) ? tseq : '0;
      out_full    <= full;
      out_last    <= last_rs;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.seq_num        = out_seq;
  assign rsp.packet_payload = out_payload;
  assign rsp.timer_cmd      = out_tcmd;
  assign rsp.timer_seq      = out_tseq;
  assign rsp.window_full    = out_full;
  assign rsp.last           = out_last;

  // The window never holds more than its size, and the sequence span
  // between head and next number always equals the outstanding count.
  `GBN_ASSERT_IMP(a_count_bound, clk, rst, 1'b1,
                  count <= gbn_pkg::cnt_t'(gbn_pkg::WINDOW_SIZE))
  `GBN_ASSERT_IMP(a_span_matches_count, clk, rst, 1'b1,
                  gbn_pkg::cnt_t'(gbn_pkg::seq_t'(next_seq - base_seq)) == count)
  `GBN_ASSERT_IMP(a_no_accept_in_burst, clk, rst, state == gbn_pkg::S_EMIT, !req.ready)
  `GBN_ASSERT_NXT(a_burst_starts, clk, rst, acc && is_timeout && count != '0,
                  state == gbn_pkg::S_EMIT && out_valid == $past(out_valid && !rsp.ready))
  `GBN_ASSERT_NXT(a_burst_ends, clk, rst, load_rs && last_rs,
                  state == gbn_pkg::S_IDLE && out_valid && out_last)

endmodule
